// ===== hw/rtl/hpt_pkg.sv =====
// Shared constants, payload types and register codes of the homography point transform.
// No dependencies; every other file of the block takes its names from here.

package hpt_pkg;

    // Field formats
    localparam int COORD_WIDTH    = 20;
    localparam int COORD_FRAC     = 4;
    localparam int COEF_WIDTH     = 32;
    localparam int COEF_FRAC_BITS = 24;
    localparam int OUT_WIDTH      = 24;
    localparam int OUT_FRAC       = 16;

    // Datapath widths: product, exact affine sum and its magnitude
    localparam int PROD_WIDTH = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 1;
    localparam int MAG_WIDTH  = SUM_WIDTH - 1;

    // Divider: quotient bits produced, one per step, and rounded quotient width
    localparam int QUO_BITS  = OUT_WIDTH;
    localparam int PRE_SHIFT = QUO_BITS - OUT_FRAC;
    localparam int QR_WIDTH  = QUO_BITS + 1;

    // Pipeline depth: two affine stages, then abs, range check, steps, round, clip
    localparam int AFFINE_STAGES = 2;
    localparam int DIV_STAGES    = QUO_BITS + 4;
    localparam int PIPE_DEPTH    = AFFINE_STAGES + DIV_STAGES;

    // Output clip bounds
    localparam logic [QR_WIDTH-1:0] POS_LIMIT = QR_WIDTH'((1 << (OUT_WIDTH - 1)) - 1);
    localparam logic [QR_WIDTH-1:0] NEG_LIMIT = QR_WIDTH'(1 << (OUT_WIDTH - 1));
    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = OUT_WIDTH'((1 << (OUT_WIDTH - 1)) - 1);
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = OUT_WIDTH'(1 << (OUT_WIDTH - 1));

    // Configuration port
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 2 * COEF_WIDTH;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ROW0_AB      = 3'd0,
        CFG_ROW0C_ROW1A  = 3'd1,
        CFG_ROW1_BC      = 3'd2,
        CFG_ROW2_AB      = 3'd3,
        CFG_ROW2_C       = 3'd4
    } cfg_reg_t;

    // Reset matrix values
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;
    localparam logic [CFG_DATA_WIDTH-1:0] ROW0_AB_RESET     = {COEF_ONE, {COEF_WIDTH{1'b0}}};
    localparam logic [CFG_DATA_WIDTH-1:0] ROW0C_ROW1A_RESET = '0;
    localparam logic [CFG_DATA_WIDTH-1:0] ROW1_BC_RESET     = {{COEF_WIDTH{1'b0}}, COEF_ONE};
    localparam logic [CFG_DATA_WIDTH-1:0] ROW2_AB_RESET     = '0;
    localparam logic [COEF_WIDTH-1:0]     ROW2_C_RESET      = COEF_ONE;

    // Input word
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
    } point_t;

    // Output word
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] mapped_x;
        logic signed [OUT_WIDTH-1:0] mapped_y;
        logic                        degenerate;
        logic                        saturated;
    } result_t;

    // State handed from one divider step to the next
    typedef struct packed {
        logic [MAG_WIDTH-1:0] rem;
        logic [MAG_WIDTH-1:0] dvs;
        logic [QUO_BITS-1:0]  quo;
        logic [QUO_BITS-1:0]  nbits;
        logic                 neg;
        logic                 ovf;
    } div_state_t;

    // Clipped quotient and its status
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] value;
        logic                        sat;
    } quo_res_t;

endpackage

// ===== hw/rtl/hpt_affine.sv =====
// Two-stage affine form a*x + b*y + (c << 4), formed exactly.
// Depends on hpt_pkg for widths.

module hpt_affine (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [hpt_pkg::COORD_WIDTH-1:0] x,
    input  logic signed [hpt_pkg::COORD_WIDTH-1:0] y,
    input  logic signed [hpt_pkg::COEF_WIDTH-1:0]  coef_a,
    input  logic signed [hpt_pkg::COEF_WIDTH-1:0]  coef_b,
    input  logic signed [hpt_pkg::COEF_WIDTH-1:0]  coef_c,
    output logic signed [hpt_pkg::SUM_WIDTH-1:0]   sum
);

    logic signed [hpt_pkg::PROD_WIDTH-1:0] prod_a_reg, prod_a_next;
    logic signed [hpt_pkg::PROD_WIDTH-1:0] prod_b_reg, prod_b_next;
    logic signed [hpt_pkg::COEF_WIDTH-1:0] offs_reg;
    logic signed [hpt_pkg::SUM_WIDTH-1:0]  sum_reg, sum_next;

    // Stage 1: the two products
    assign prod_a_next = hpt_pkg::PROD_WIDTH'(x) * hpt_pkg::PROD_WIDTH'(coef_a);
    assign prod_b_next = hpt_pkg::PROD_WIDTH'(y) * hpt_pkg::PROD_WIDTH'(coef_b);

    // Stage 2: add products and the aligned constant term
    assign sum_next = hpt_pkg::SUM_WIDTH'(prod_a_reg)
                    + hpt_pkg::SUM_WIDTH'(prod_b_reg)
                    + (hpt_pkg::SUM_WIDTH'(offs_reg) <<< hpt_pkg::COORD_FRAC);

    // Advance both stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            offs_reg   <= coef_c;
            sum_reg    <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== hw/rtl/hpt_div_step.sv =====
// One registered restoring-division step: brings in one dividend bit, yields one quotient bit.
// Depends on hpt_pkg for div_state_t.

module hpt_div_step (
    input  logic                clk,
    input  logic                en,
    input  hpt_pkg::div_state_t step_in,
    output hpt_pkg::div_state_t step_out
);

    logic [hpt_pkg::MAG_WIDTH:0]   rem_shift;
    logic [hpt_pkg::MAG_WIDTH+1:0] diff;
    logic                          fits;
    hpt_pkg::div_state_t           st_reg, st_next;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign rem_shift = {step_in.rem, step_in.nbits[hpt_pkg::QUO_BITS-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, step_in.dvs};
    assign fits      = !diff[hpt_pkg::MAG_WIDTH+1];

    always_comb
    begin
        st_next       = step_in;
        st_next.rem   = fits ? diff[hpt_pkg::MAG_WIDTH-1:0] : rem_shift[hpt_pkg::MAG_WIDTH-1:0];
        st_next.quo   = {step_in.quo[hpt_pkg::QUO_BITS-2:0], fits};
        st_next.nbits = {step_in.nbits[hpt_pkg::QUO_BITS-2:0], 1'b0};
    end

    // Hold on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign step_out = st_reg;

endmodule

// ===== hw/rtl/hpt_divider.sv =====
// Pipelined signed divider: (num << 16) / den rounded to nearest, ties away, clipped to Q8.16.
// Depends on hpt_pkg and hpt_div_step.

module hpt_divider (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [hpt_pkg::SUM_WIDTH-1:0] num,
    input  logic signed [hpt_pkg::SUM_WIDTH-1:0] den,
    output hpt_pkg::quo_res_t                   res
);

    logic [hpt_pkg::SUM_WIDTH-1:0] num_flip, den_flip;
    logic [hpt_pkg::MAG_WIDTH-1:0] nmag_reg, nmag_next;
    logic [hpt_pkg::MAG_WIDTH-1:0] dmag_reg, dmag_next;
    logic                          neg_reg, neg_next;

    hpt_pkg::div_state_t init_reg, init_next;
    hpt_pkg::div_state_t chain [0:hpt_pkg::QUO_BITS];

    hpt_pkg::div_state_t           last;
    logic                          round_up;
    logic [hpt_pkg::QR_WIDTH-1:0]  qr_reg, qr_next;
    logic                          rneg_reg, rovf_reg;

    logic [hpt_pkg::QR_WIDTH-1:0]  limit, mag;
    logic [hpt_pkg::OUT_WIDTH-1:0] mag_out;
    logic                          clip;
    hpt_pkg::quo_res_t             res_reg, res_next;

    // Stage A: magnitudes and result sign
    assign num_flip  = -num;
    assign den_flip  = -den;
    assign nmag_next = num[hpt_pkg::SUM_WIDTH-1] ? num_flip[hpt_pkg::MAG_WIDTH-1:0]
                                                 : num[hpt_pkg::MAG_WIDTH-1:0];
    assign dmag_next = den[hpt_pkg::SUM_WIDTH-1] ? den_flip[hpt_pkg::MAG_WIDTH-1:0]
                                                 : den[hpt_pkg::MAG_WIDTH-1:0];
    assign neg_next  = num[hpt_pkg::SUM_WIDTH-1] ^ den[hpt_pkg::SUM_WIDTH-1];

    // Stage B: flag quotients past the step range, seed the partial remainder
    always_comb
    begin
        init_next.ovf   = ({{hpt_pkg::PRE_SHIFT{1'b0}}, nmag_reg}
                           >= {dmag_reg, {hpt_pkg::PRE_SHIFT{1'b0}}});
        init_next.rem   = nmag_reg >> hpt_pkg::PRE_SHIFT;
        init_next.nbits = {nmag_reg[hpt_pkg::PRE_SHIFT-1:0], {hpt_pkg::OUT_FRAC{1'b0}}};
        init_next.quo   = '0;
        init_next.dvs   = dmag_reg;
        init_next.neg   = neg_reg;
    end

    assign chain[0] = init_reg;

    // One quotient bit per stage
    for (genvar k = 0; k < hpt_pkg::QUO_BITS; k++)
    begin : g_step
        hpt_div_step u_step (
            .clk      (clk),
            .en       (en),
            .step_in  (chain[k]),
            .step_out (chain[k+1])
        );
    end

    // Round: bump when twice the remainder reaches the divisor
    assign last     = chain[hpt_pkg::QUO_BITS];
    assign round_up = ({last.rem, 1'b0} >= {1'b0, last.dvs});
    assign qr_next  = {1'b0, last.quo} + hpt_pkg::QR_WIDTH'(round_up);

    // Clip to the signed output range and apply the sign
    assign limit   = rneg_reg ? hpt_pkg::NEG_LIMIT : hpt_pkg::POS_LIMIT;
    assign clip    = rovf_reg || (qr_reg > limit);
    assign mag     = clip ? limit : qr_reg;
    assign mag_out = mag[hpt_pkg::OUT_WIDTH-1:0];

    always_comb
    begin
        res_next.value = rneg_reg ? -mag_out : mag_out;
        res_next.sat   = clip;
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= nmag_next;
            dmag_reg <= dmag_next;
            neg_reg  <= neg_next;
            init_reg <= init_next;
            qr_reg   <= qr_next;
            rneg_reg <= last.neg;
            rovf_reg <= last.ovf;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/hpt_skid.sv =====
// Output register plus one skid word; parts the pipeline enable from the receiver's ready.
// Depends on hpt_pkg for result_t.

module hpt_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  hpt_pkg::result_t up_word,
    output logic             dn_valid,
    input  logic             dn_ready,
    output hpt_pkg::result_t dn_word
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    hpt_pkg::result_t out_word_reg, out_word_next;
    hpt_pkg::result_t skid_word_reg, skid_word_next;
    logic             take;

    assign up_ready = !skid_valid_reg;
    assign take     = up_valid && !skid_valid_reg;

    // Drain the skid word first, else pass the new word, else park it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || dn_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = take;
                if (take)
                begin
                    out_word_next = up_word;
                end
            end
        end
        else if (take)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = up_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign dn_valid = out_valid_reg;
    assign dn_word  = out_word_reg;

    // A parked word always sits behind a presented one
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    // Park only when the presented word was stalled
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !dn_ready))
        else $error("skid word filled without a downstream stall");

endmodule

// ===== hw/rtl/homography_point_transform.sv =====
// Top level of the homography point transform: coefficient registers, affine forms,
// dividers and output buffer. Depends on hpt_pkg, hpt_affine, hpt_divider, hpt_skid.
//
// Usage:
//   point channel (point_valid/point_ready/point) takes one (pos_x, pos_y) word per
//   cycle, signed Q16.4. result channel (result_valid/result_ready/result) returns
//   mapped_x, mapped_y in signed Q8.16 plus degenerate and saturated flags, one word
//   per point, in order.
//   Coefficients m0..m8 (signed Q8.24) are written through cfg_wen/cfg_idx/cfg_data,
//   one 64-bit register per write, no wait; write only while no point is in flight.
//   Throughput: one point per cycle while point_ready is high. Most of the pipeline
//   from acceptance to result_valid is the divider's 24 one-bit subtract stages.
//   Reset: empties the pipeline and loads the default matrix (m1 = m4 = m8 = 1.0,
//   others 0). point_ready is high from the first cycle after reset.
//   Stall: when result_ready is low, one more word parks in a skid register; after
//   that point_ready drops and the whole pipeline holds until the receiver drains it.

module homography_point_transform (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 point_valid,
    output logic                                 point_ready,
    input  hpt_pkg::point_t                      point,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output hpt_pkg::result_t                     result,
    input  logic                                 cfg_wen,
    input  logic [hpt_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx,
    input  logic [hpt_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int CW = hpt_pkg::COEF_WIDTH;

    logic [hpt_pkg::CFG_DATA_WIDTH-1:0] row0_ab_reg, row0_ab_next;
    logic [hpt_pkg::CFG_DATA_WIDTH-1:0] row0c_row1a_reg, row0c_row1a_next;
    logic [hpt_pkg::CFG_DATA_WIDTH-1:0] row1_bc_reg, row1_bc_next;
    logic [hpt_pkg::CFG_DATA_WIDTH-1:0] row2_ab_reg, row2_ab_next;
    logic [CW-1:0]                      row2_c_reg, row2_c_next;

    logic signed [CW-1:0] m0, m1, m2, m3, m4, m5, m6, m7, m8;

    logic                                 pipe_en;
    logic [hpt_pkg::PIPE_DEPTH-1:0]       vld_reg, vld_next;
    logic [hpt_pkg::DIV_STAGES-1:0]       deg_reg, deg_next;
    logic signed [hpt_pkg::SUM_WIDTH-1:0] nx_sum, ny_sum, w_sum;
    logic                                 w_zero;
    hpt_pkg::quo_res_t                    qx, qy;
    hpt_pkg::result_t                     final_word;

    // Configuration writes; unknown indexes are dropped
    always_comb
    begin
        row0_ab_next     = row0_ab_reg;
        row0c_row1a_next = row0c_row1a_reg;
        row1_bc_next     = row1_bc_reg;
        row2_ab_next     = row2_ab_reg;
        row2_c_next      = row2_c_reg;
        if (cfg_wen)
        begin
            case (cfg_idx)
                hpt_pkg::CFG_ROW0_AB:     row0_ab_next     = cfg_data;
                hpt_pkg::CFG_ROW0C_ROW1A: row0c_row1a_next = cfg_data;
                hpt_pkg::CFG_ROW1_BC:     row1_bc_next     = cfg_data;
                hpt_pkg::CFG_ROW2_AB:     row2_ab_next     = cfg_data;
                hpt_pkg::CFG_ROW2_C:      row2_c_next      = cfg_data[CW-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_ab_reg     <= hpt_pkg::ROW0_AB_RESET;
            row0c_row1a_reg <= hpt_pkg::ROW0C_ROW1A_RESET;
            row1_bc_reg     <= hpt_pkg::ROW1_BC_RESET;
            row2_ab_reg     <= hpt_pkg::ROW2_AB_RESET;
            row2_c_reg      <= hpt_pkg::ROW2_C_RESET;
        end
        else
        begin
            row0_ab_reg     <= row0_ab_next;
            row0c_row1a_reg <= row0c_row1a_next;
            row1_bc_reg     <= row1_bc_next;
            row2_ab_reg     <= row2_ab_next;
            row2_c_reg      <= row2_c_next;
        end
    end

    // Unpack the matrix
    assign m0 = row0_ab_reg[CW-1:0];
    assign m1 = row0_ab_reg[2*CW-1:CW];
    assign m2 = row0c_row1a_reg[CW-1:0];
    assign m3 = row0c_row1a_reg[2*CW-1:CW];
    assign m4 = row1_bc_reg[CW-1:0];
    assign m5 = row1_bc_reg[2*CW-1:CW];
    assign m6 = row2_ab_reg[CW-1:0];
    assign m7 = row2_ab_reg[2*CW-1:CW];
    assign m8 = row2_c_reg;

    // Whole pipeline advances unless the skid word is occupied
    assign point_ready = pipe_en;

    hpt_affine u_aff_nx (
        .clk (clk), .en (pipe_en), .x (point.pos_x), .y (point.pos_y),
        .coef_a (m0), .coef_b (m1), .coef_c (m2), .sum (nx_sum)
    );

    hpt_affine u_aff_ny (
        .clk (clk), .en (pipe_en), .x (point.pos_x), .y (point.pos_y),
        .coef_a (m3), .coef_b (m4), .coef_c (m5), .sum (ny_sum)
    );

    hpt_affine u_aff_w (
        .clk (clk), .en (pipe_en), .x (point.pos_x), .y (point.pos_y),
        .coef_a (m6), .coef_b (m7), .coef_c (m8), .sum (w_sum)
    );

    hpt_divider u_div_x (
        .clk (clk), .en (pipe_en), .num (nx_sum), .den (w_sum), .res (qx)
    );

    hpt_divider u_div_y (
        .clk (clk), .en (pipe_en), .num (ny_sum), .den (w_sum), .res (qy)
    );

    // Carry valid bits and the zero-denominator flag alongside the data
    assign w_zero   = (w_sum == '0);
    assign vld_next = {vld_reg[hpt_pkg::PIPE_DEPTH-2:0], point_valid};
    assign deg_next = {deg_reg[hpt_pkg::DIV_STAGES-2:0], w_zero};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            deg_reg <= deg_next;
        end
    end

    // Force a zero result on a zero denominator
    always_comb
    begin
        if (deg_reg[hpt_pkg::DIV_STAGES-1])
        begin
            final_word.mapped_x   = '0;
            final_word.mapped_y   = '0;
            final_word.degenerate = 1'b1;
            final_word.saturated  = 1'b0;
        end
        else
        begin
            final_word.mapped_x   = qx.value;
            final_word.mapped_y   = qy.value;
            final_word.degenerate = 1'b0;
            final_word.saturated  = qx.sat | qy.sat;
        end
    end

    hpt_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vld_reg[hpt_pkg::PIPE_DEPTH-1]),
        .up_ready (pipe_en),
        .up_word  (final_word),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_word  (result)
    );

    // A held pipeline keeps its valid bits
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg))
        else $error("valid bits moved while the pipeline was held");

    // Degenerate words carry zero coordinates and no clip flag
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.degenerate) |->
            (result.mapped_x == '0 && result.mapped_y == '0 && !result.saturated))
        else $error("degenerate word with nonzero payload");

    // A clipped word has a coordinate at a range bound
    a_saturated_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.saturated) |->
            (result.mapped_x == hpt_pkg::OUT_MAX || result.mapped_x == hpt_pkg::OUT_MIN ||
             result.mapped_y == hpt_pkg::OUT_MAX || result.mapped_y == hpt_pkg::OUT_MIN))
        else $error("saturated word without a coordinate at a bound");

endmodule

// ===== test/tb_homography_point_transform.sv =====
// Testbench for homography_point_transform: drives points through the valid/ready channel,
// predicts each mapped point and checks the result stream in order.
// Depends on hpt_pkg and the homography_point_transform top level.
`timescale 1ns / 100ps

module tb_homography_point_transform;
    import hpt_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_POINTS = 2000;
    localparam int MAX_REPORTS   = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = PIPE_DEPTH + 10;
    localparam int NUM_REGS      = 5;
    localparam int NUM_COEFS     = 9;

    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
    localparam logic [COEF_WIDTH-1:0]  COEF_MAX  = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
    localparam logic [COEF_WIDTH-1:0]  COEF_MIN  = {1'b1, {(COEF_WIDTH - 1){1'b0}}};

    // Expected mapped points, with a private copy of the coefficient registers
    class mapped_point_board;
        logic [CFG_DATA_WIDTH-1:0] coef_regs [NUM_REGS];
        result_t pending_maps [$];
        int n_points;
        int n_results;
        int n_degenerate;
        int n_saturated;
        int n_mismatches;

        function new();
            coef_regs[CFG_ROW0_AB]     = ROW0_AB_RESET;
            coef_regs[CFG_ROW0C_ROW1A] = ROW0C_ROW1A_RESET;
            coef_regs[CFG_ROW1_BC]     = ROW1_BC_RESET;
            coef_regs[CFG_ROW2_AB]     = ROW2_AB_RESET;
            coef_regs[CFG_ROW2_C]      = CFG_DATA_WIDTH'(ROW2_C_RESET);
        endfunction

        // Unused indexes are dropped; the constant term keeps only its low word
        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                CFG_ROW0_AB, CFG_ROW0C_ROW1A, CFG_ROW1_BC, CFG_ROW2_AB: coef_regs[idx] = data;
                CFG_ROW2_C: coef_regs[idx] = {{COEF_WIDTH{1'b0}}, data[COEF_WIDTH-1:0]};
                default: ;
            endcase
        endfunction

        // Coefficient k of m0..m8: even k in the low half, odd k in the high half
        function logic signed [COEF_WIDTH-1:0] coef(int k);
            return (k % 2) ? coef_regs[k / 2][CFG_DATA_WIDTH-1:COEF_WIDTH]
                           : coef_regs[k / 2][COEF_WIDTH-1:0];
        endfunction

        // Exact a*x + b*y + c, with c aligned to the coordinate fraction
        function longint affine_sum(int row, longint x, longint y);
            longint a;
            longint b;
            longint c;
            a = coef(3 * row);
            b = coef(3 * row + 1);
            c = coef(3 * row + 2);
            return x * a + y * b + (c <<< COORD_FRAC);
        endfunction

        // Quotient in Q8.16, rounded half away from zero, clipped to the output range
        function logic [OUT_WIDTH-1:0] divide_round(longint num, longint den, inout logic sat);
            logic [127:0] num_mag;
            logic [127:0] den_mag;
            logic [127:0] quo;
            logic [127:0] rem;
            logic [127:0] bound;
            logic         neg;
            neg     = (num < 0) != (den < 0);
            num_mag = {64'b0, 64'(num < 0 ? -num : num)} << OUT_FRAC;
            den_mag = {64'b0, 64'(den < 0 ? -den : den)};
            quo     = num_mag / den_mag;
            rem     = num_mag % den_mag;
            if (rem >= den_mag - rem)
                quo = quo + 1;
            bound = neg ? 128'(NEG_LIMIT) : 128'(POS_LIMIT);
            if (quo > bound)
            begin
                quo = bound;
                sat = 1'b1;
            end
            return neg ? OUT_WIDTH'(-quo) : OUT_WIDTH'(quo);
        endfunction

        function void note_point(point_t p);
            longint  x;
            longint  y;
            longint  w;
            logic    sat;
            result_t r;
            x   = $signed(p.pos_x);
            y   = $signed(p.pos_y);
            w   = affine_sum(2, x, y);
            sat = 1'b0;
            r   = '0;
            if (w == 0)
                r.degenerate = 1'b1;
            else
            begin
                r.mapped_x  = divide_round(affine_sum(0, x, y), w, sat);
                r.mapped_y  = divide_round(affine_sum(1, x, y), w, sat);
                r.saturated = sat;
            end
            pending_maps = {pending_maps, r};
            n_points++;
        endfunction

        function void report(string field, longint want, longint got);
            n_mismatches++;
            if (n_mismatches <= MAX_REPORTS)
                $error("point %0d: %s expected %0d, got %0d", n_results, field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_maps.size() == 0)
            begin
                n_mismatches++;
                if (n_mismatches <= MAX_REPORTS)
                    $error("result word with no point pending: x=%0d y=%0d",
                           got.mapped_x, got.mapped_y);
                return;
            end
            want = pending_maps.pop_front();
            if (got.mapped_x !== want.mapped_x)
                report("mapped_x", want.mapped_x, got.mapped_x);
            if (got.mapped_y !== want.mapped_y)
                report("mapped_y", want.mapped_y, got.mapped_y);
            if (got.degenerate !== want.degenerate)
                report("degenerate", want.degenerate, got.degenerate);
            if (got.saturated !== want.saturated)
                report("saturated", want.saturated, got.saturated);
            n_results++;
            n_degenerate += want.degenerate;
            n_saturated  += want.saturated;
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        point_valid;
    logic                        point_ready;
    point_t                      point;
    logic                        result_valid;
    logic                        result_ready = 1'b0;
    result_t                     result;
    logic                        cfg_wen;
    logic [CFG_IDX_WIDTH-1:0]    cfg_idx;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data;

    mapped_point_board board;
    logic [COEF_WIDTH-1:0] mat [NUM_COEFS];
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_left     = 0;
    int  cycle_count   = 0;
    int  n_cfg_writes  = 0;
    bit  near_line     = 1'b0;

    homography_point_transform dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wen      (cfg_wen),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[homography_point_transform] ERROR");
            $finish;
        end
    end

    // Receive side: check each word taken, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result);
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one point, idling first at the current rate, and hold it until taken
    task automatic send_point(point_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point       <= p;
        @(posedge clk);
        while (!point_ready)
            @(posedge clk);
        board.note_point(p);
    endtask

    // Drop valid and wait for every pending result
    task automatic wait_drained();
        point_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_maps.size() != 0);
    endtask

    // Leaves the write enable high; cfg_close lowers it after a batch
    task automatic cfg_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        cfg_wen  <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
        n_cfg_writes++;
    endtask

    task automatic cfg_close();
        cfg_wen <= 1'b0;
    endtask

    // Write m0..m8 from mat; junk in the unused upper half of the constant register
    task automatic load_matrix();
        cfg_write(CFG_ROW0_AB,     {mat[1], mat[0]});
        cfg_write(CFG_ROW0C_ROW1A, {mat[3], mat[2]});
        cfg_write(CFG_ROW1_BC,     {mat[5], mat[4]});
        cfg_write(CFG_ROW2_AB,     {mat[7], mat[6]});
        cfg_write(CFG_ROW2_C,      {COEF_WIDTH'($urandom), mat[8]});
        cfg_close();
    endtask

    function automatic point_t mk_point(int x, int y);
        point_t p;
        p.pos_x = COORD_WIDTH'(x);
        p.pos_y = COORD_WIDTH'(y);
        return p;
    endfunction

    function automatic logic [COEF_WIDTH-1:0] rand_sign(logic [COEF_WIDTH-1:0] mag);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic logic [COEF_WIDTH-1:0] rand_coef();
        logic [COEF_WIDTH-1:0] v;
        case ($urandom_range(7))
            0: v = '0;
            1, 2: v = $urandom;
            3: v = $urandom_range(1) ? COEF_MAX : COEF_MIN;
            default: v = rand_sign($urandom >> $urandom_range(31));
        endcase
        return v;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        logic [COORD_WIDTH-1:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: v = COORD_MIN;
                    1: v = COORD_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            1, 2, 3, 4: v = COORD_WIDTH'($urandom);
            default: v = COORD_WIDTH'($urandom_range(8191) - 4096);
        endcase
        return v;
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.pos_x = rand_coord();
        p.pos_y = rand_coord();
        if (near_line && $urandom_range(3) == 0)
            p.pos_x = COORD_WIDTH'(16);
        return p;
    endfunction

    // Pick a matrix: wild, fully degenerate, degenerate along x = 1.0, or camera-like
    task automatic make_random_matrix();
        near_line = 1'b0;
        case ($urandom_range(7))
            0:
            begin
                foreach (mat[k])
                    mat[k] = rand_coef();
            end
            1:
            begin
                foreach (mat[k])
                    mat[k] = rand_coef();
                mat[6] = '0;
                mat[7] = '0;
                mat[8] = '0;
            end
            2:
            begin
                foreach (mat[k])
                    mat[k] = rand_coef();
                mat[6]    = rand_sign($urandom_range(1, 1 << 20));
                mat[7]    = '0;
                mat[8]    = -mat[6];
                near_line = 1'b1;
            end
            default:
            begin
                mat[0] = rand_sign($urandom_range(1 << 12, 1 << 20));
                mat[1] = rand_sign($urandom_range(0, 1 << 14));
                mat[2] = rand_sign($urandom_range(0, 1 << 26));
                mat[3] = rand_sign($urandom_range(0, 1 << 14));
                mat[4] = rand_sign($urandom_range(1 << 12, 1 << 20));
                mat[5] = rand_sign($urandom_range(0, 1 << 26));
                mat[6] = rand_sign($urandom_range(0, 1 << 8));
                mat[7] = rand_sign($urandom_range(0, 1 << 8));
                mat[8] = COEF_ONE + rand_sign($urandom_range(0, 1 << 22));
            end
        endcase
    endtask

    initial
    begin
        int  mode_points;
        int  batch;
        bit  held;
        bit  paused;
        board       = new();
        rst_n       = 1'b0;
        point_valid = 1'b0;
        point       = '0;
        cfg_wen     = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        held        = 1'b0;
        paused      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset matrix: coordinate extremes, small values and clipping both ways
        send_point(mk_point(0, 0));
        send_point(mk_point(1, -1));
        send_point(mk_point(int'(COORD_MAX), int'(COORD_MAX)));
        send_point(mk_point(int'(COORD_MIN), int'(COORD_MIN)));
        send_point(mk_point(int'(COORD_MAX), int'(COORD_MIN)));
        wait_drained();

        // Writes to unused indexes must leave the matrix alone
        for (int i = int'(CFG_ROW2_C) + 1; i < (1 << CFG_IDX_WIDTH); i++)
            cfg_write(CFG_IDX_WIDTH'(i), {$urandom, $urandom});
        cfg_close();
        send_point(mk_point(16, 32));
        send_point(mk_point(-5, 7));
        wait_drained();

        // Zero denominator everywhere
        foreach (mat[k])
            mat[k] = $urandom;
        mat[6] = '0;
        mat[7] = '0;
        mat[8] = '0;
        load_matrix();
        send_point(mk_point(int'(COORD_MAX), int'(COORD_MIN)));
        send_point(mk_point(123, -456));
        wait_drained();

        // Zero denominator only at x = 1.0
        mat[6] = COEF_ONE;
        mat[8] = -COEF_ONE;
        load_matrix();
        send_point(mk_point(16, 99));
        send_point(mk_point(17, 99));
        wait_drained();

        // Quotients of exactly one half LSB: ties round away from zero
        foreach (mat[k])
            mat[k] = '0;
        mat[0] = 1;
        mat[8] = 1 << 13;
        load_matrix();
        send_point(mk_point(1, 0));
        send_point(mk_point(-1, 0));
        send_point(mk_point(3, 5));
        wait_drained();

        // Extreme coefficients
        foreach (mat[k])
            mat[k] = COEF_MIN;
        load_matrix();
        send_point(mk_point(int'(COORD_MAX), int'(COORD_MIN)));
        send_point(mk_point(0, 0));
        send_point(mk_point(int'(COORD_MIN), int'(COORD_MIN)));
        wait_drained();
        foreach (mat[k])
            mat[k] = COEF_MAX;
        load_matrix();
        send_point(mk_point(int'(COORD_MAX), int'(COORD_MAX)));
        send_point(mk_point(-1, 1));
        wait_drained();

        // Random batches, one matrix each, under three idling patterns
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            mode_points = 0;
            while (mode_points < RANDOM_POINTS / 3)
            begin
                wait_drained();
                make_random_matrix();
                load_matrix();
                batch = $urandom_range(20, 120);
                // Long receiver stall while points keep coming: the pipeline backs up
                if (mode == 2 && !held)
                begin
                    hold_left = HOLD_CYCLES;
                    held      = 1'b1;
                    batch     = 4 * PIPE_DEPTH;
                end
                for (int i = 0; i < batch; i++)
                begin
                    // Once, stop mid-batch until everything has come out
                    if (mode == 1 && !paused && i == batch / 2)
                    begin
                        wait_drained();
                        paused = 1'b1;
                    end
                    send_point(rand_point());
                end
                mode_points += batch;
            end
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.pending_maps.size() != 0)
        begin
            $error("%0d results never arrived", board.pending_maps.size());
            board.n_mismatches++;
        end
        $display("Mapped %0d points through %0d register writes; %0d results checked.",
                 board.n_points, n_cfg_writes, board.n_results);
        $display("Of these %0d had a zero denominator and %0d were clipped; %0d mismatches.",
                 board.n_degenerate, board.n_saturated, board.n_mismatches);
        if (board.n_mismatches == 0)
            $display("[homography_point_transform] OK");
        else
            $display("[homography_point_transform] ERROR");
        $finish;
    end

endmodule
